/* rtl/assert_macros.svh */
// assertion macros shared by the rtl of the priority insert queue
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent on one edge implies consequent on the same edge
`define TPIQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent on one edge implies consequent on the next edge
`define TPIQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tpiq_pkg.sv */
// package of the priority insert queue: depth, widths, codes and cell control
// no dependencies
`timescale 1ns / 1ps

package tpiq_pkg;

  // queue geometry
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  // field widths
  localparam int unsigned ValW  = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned StatW = 2;
  localparam int unsigned OccW  = 5;

  // threshold after reset
  localparam logic [ValW-1:0] ThrReset = 8'd60;

  // operation codes
  typedef enum logic [KindW-1:0] {
    K_PLAIN  = 2'd0,
    K_PRIO   = 2'd1,
    K_REMOVE = 2'd2
  } kind_t;

  // result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic prio_ins;
    logic tail_ins;
    logic pop;
  } cell_op_t;

endpackage

/* rtl/tpiq_cell.sv */
// one storage cell of the priority insert queue
// depends on tpiq_pkg
`timescale 1ns / 1ps

module tpiq_cell (
  input  logic                     clk,
  input  tpiq_pkg::cell_op_t       op,
  input  logic [tpiq_pkg::ValW-1:0] thr,
  input  logic [tpiq_pkg::ValW-1:0] new_value,
  input  logic                     occ,
  input  logic                     occ_prev,
  input  logic                     run_in,
  input  logic [tpiq_pkg::ValW-1:0] left_entry,
  input  logic [tpiq_pkg::ValW-1:0] right_entry,
  output logic                     run_out,
  output logic [tpiq_pkg::ValW-1:0] entry
);
  import tpiq_pkg::*;

  logic            ins_here;
  logic [ValW-1:0] entry_next;

  // this cell continues the leading run of priority entries
  assign run_out  = run_in & occ & (entry >= thr);
  // first cell past the run takes a priority value
  assign ins_here = run_in & ~run_out;

  // local shift or load decision
  always_comb begin
    entry_next = entry;
    if (op.prio_ins) begin
      if (ins_here) begin
        entry_next = new_value;
      end else if (!run_in && occ_prev) begin
        entry_next = left_entry;
      end
    end else if (op.tail_ins) begin
      if (occ_prev && !occ) begin
        entry_next = new_value;
      end
    end else if (op.pop) begin
      if (occ) begin
        entry_next = right_entry;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

/* rtl/threshold_priority_insert_queue.sv */
// top level of the priority insert queue: control, fill count, row of cells
// depends on tpiq_pkg, tpiq_cell and assert_macros.svh
`timescale 1ns / 1ps
//
//  channel  | signals                                     | role
//  ---------+---------------------------------------------+---------------------------
//  in       | in_valid, in_ready, kind, value             | operation requests
//  out      | out_valid, out_ready, removed_value,        | one result per request
//           | removed_valid, status, occupancy            |
//  cfg      | cfg_we, cfg_wdata                           | priority threshold write
//
//  one request is taken per cycle while no result waits untaken; its result shows
//  in the output register in the next cycle, and the next request is taken while
//  that result is being taken. every cell shifts or loads in the same edge; the
//  insert point is found by the run signal that passes from cell to cell.
//  rst clears the fill count, the result valid and sets the threshold to 60.
//  a stalled output holds off new requests only while the result is not taken.

`include "assert_macros.svh"

module threshold_priority_insert_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tpiq_pkg::KindW-1:0] kind,
  input  logic [tpiq_pkg::ValW-1:0]  value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tpiq_pkg::ValW-1:0]  removed_value,
  output logic                       removed_valid,
  output logic [tpiq_pkg::StatW-1:0] status,
  output logic [tpiq_pkg::OccW-1:0]  occupancy,
  input  logic                       cfg_we,
  input  logic [tpiq_pkg::ValW-1:0]  cfg_wdata
);
  import tpiq_pkg::*;

  logic [ValW-1:0] thr;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            in_fire;
  logic            full;
  logic            empty;
  kind_t           op_kind;
  cell_op_t        op;
  status_t         stat_next;
  logic [ValW-1:0] rem_next;
  logic            rem_valid_next;

  logic [ValW-1:0] entry_q [QueueDepth];
  logic            run_c   [QueueDepth+1];
  logic            occ_c   [QueueDepth+1];

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = (count == CntW'(QueueDepth));
  assign empty    = (count == '0);
  assign op_kind  = kind_t'(kind);

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= ThrReset;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // decode the request into cell operations and a result
  always_comb begin
    op             = '0;
    count_next     = count;
    stat_next      = ST_OK;
    rem_next       = '0;
    rem_valid_next = 1'b0;
    case (op_kind)
      K_PLAIN, K_PRIO: begin
        if (full) begin
          stat_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
          if (op_kind == K_PRIO && value >= thr) begin
            op.prio_ins = in_fire;
          end else begin
            op.tail_ins = in_fire;
          end
        end
      end
      K_REMOVE: begin
        if (empty) begin
          stat_next = ST_EMPTY;
        end else begin
          count_next     = count - 1'b1;
          op.pop         = in_fire;
          rem_next       = entry_q[0];
          rem_valid_next = 1'b1;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_fire) begin
      count <= count_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      removed_value <= rem_next;
      removed_valid <= rem_valid_next;
      status        <= stat_next;
      occupancy     <= OccW'(count_next);
    end
  end

  // head of the run chain: cell 0 always starts the run and follows the head
  assign run_c[0] = 1'b1;
  assign occ_c[0] = 1'b1;

  // row of cells
  genvar gi;
  generate
    for (gi = 0; gi < QueueDepth; gi++) begin : g_cell
      logic [ValW-1:0] left_e;
      logic [ValW-1:0] right_e;

      assign occ_c[gi+1] = (CntW'(gi) < count);

      if (gi == 0) begin : g_left_edge
        assign left_e = value;
      end else begin : g_left_mid
        assign left_e = entry_q[gi-1];
      end

      if (gi == QueueDepth - 1) begin : g_right_edge
        assign right_e = entry_q[gi];
      end else begin : g_right_mid
        assign right_e = entry_q[gi+1];
      end

      tpiq_cell u_cell (
        .clk         (clk),
        .op          (op),
        .thr         (thr),
        .new_value   (value),
        .occ         (occ_c[gi+1]),
        .occ_prev    (occ_c[gi]),
        .run_in      (run_c[gi]),
        .left_entry  (left_e),
        .right_entry (right_e),
        .run_out     (run_c[gi+1]),
        .entry       (entry_q[gi])
      );
    end
  endgenerate

  // checks
  `TPIQ_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CntW'(QueueDepth), "count over depth")
  `TPIQ_ASSERT_NEXT(a_insert_grows, clk, rst,
    in_fire && (op_kind == K_PLAIN || op_kind == K_PRIO) && !full,
    count == $past(count) + 1'b1, "insert did not grow count")
  `TPIQ_ASSERT_NEXT(a_pop_head, clk, rst, in_fire && op_kind == K_REMOVE && !empty,
    removed_valid && removed_value == $past(entry_q[0]), "pop lost the head")
  `TPIQ_ASSERT_SAME(a_removed_ok, clk, rst, out_valid && removed_valid,
    status == ST_OK, "popped value with error status")

endmodule

/* bench/tpiq_result_checker.sv */
`timescale 1ns / 1ps
// result checker of the priority insert queue: keeps its own copy of the queue,
// predicts the result of every accepted request and compares it; depends on tpiq_pkg

module tpiq_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [tpiq_pkg::KindW-1:0] kind,
  input  logic [tpiq_pkg::ValW-1:0]  value,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [tpiq_pkg::ValW-1:0]  removed_value,
  input  logic                       removed_valid,
  input  logic [tpiq_pkg::StatW-1:0] status,
  input  logic [tpiq_pkg::OccW-1:0]  occupancy,
  input  logic                       cfg_we,
  input  logic [tpiq_pkg::ValW-1:0]  cfg_wdata,
  output int                         mismatch_count,
  output int                         results_owed
);
  import tpiq_pkg::*;

  typedef struct packed {
    logic [ValW-1:0] removed_value;
    logic            removed_valid;
    status_t         status;
    logic [OccW-1:0] occupancy;
  } queue_result_t;

  queue_result_t   awaited_results[$];
  logic [ValW-1:0] held_entries[$];
  logic [ValW-1:0] prio_threshold;

  // one operation on the shadow queue, giving the result it should produce
  function automatic queue_result_t apply_queue_op(input logic [KindW-1:0] op,
                                                   input logic [ValW-1:0]  val);
    queue_result_t res;
    int            slot;
    res = '0;
    case (op)
      K_PLAIN, K_PRIO: begin
        if (held_entries.size() >= QueueDepth) begin
          res.status = ST_FULL;
        end else if (op == K_PRIO && val >= prio_threshold) begin
          // slot sits right after the leading run of priority entries
          slot = 0;
          while (slot < held_entries.size() && held_entries[slot] >= prio_threshold)
            slot++;
          held_entries.insert(slot, val);
        end else begin
          held_entries.push_back(val);
        end
      end
      K_REMOVE: begin
        if (held_entries.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed_value = held_entries.pop_front();
          res.removed_valid = 1'b1;
        end
      end
      default: ;  // unused code leaves the queue alone
    endcase
    res.occupancy = OccW'(held_entries.size());
    return res;
  endfunction

  task automatic check_field(input string field, input logic [ValW-1:0] want,
                             input logic [ValW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // track requests and results on every rising edge
  always @(posedge clk) begin : monitor
    queue_result_t want;
    if (rst) begin
      awaited_results.delete();
      held_entries.delete();
      prio_threshold = ThrReset;
    end else begin
      if (in_valid && in_ready)
        awaited_results.push_back(apply_queue_op(kind, value));
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none got %0d/%0d/%0d/%0d",
                   $time, removed_value, removed_valid, status, occupancy);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("removed_value", want.removed_value, removed_value);
          check_field("removed_valid", want.removed_valid, removed_valid);
          check_field("status", want.status, status);
          check_field("occupancy", want.occupancy, occupancy);
        end
      end
      // the bench must change the threshold only while the queue is idle; this checker does not enforce it
      if (cfg_we)
        prio_threshold = cfg_wdata;
    end
    results_owed = awaited_results.size();
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// testbench top of the priority insert queue: clock, reset, requests, threshold
// writes and verdict; depends on tpiq_pkg, tpiq_result_checker and the queue rtl

module tb;
  import tpiq_pkg::*;

  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int ResetCycles   = 6;
  localparam int SettleCycles  = 3;
  localparam int HoldOffCycles = 64;
  localparam int WatchdogLimit = 1000;
  localparam int PhaseCount    = 10;
  localparam int PhaseItems    = 138;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [KindW-1:0] kind;
  logic [ValW-1:0]  value;
  logic             out_valid;
  logic             out_ready;
  logic [ValW-1:0]  removed_value;
  logic             removed_valid;
  logic [StatW-1:0] status;
  logic [OccW-1:0]  occupancy;
  logic             cfg_we;
  logic [ValW-1:0]  cfg_wdata;
  int               mismatch_count;
  int               results_owed;

  logic             idle_on;
  int               stall_req;
  logic [ValW-1:0]  cur_thr;

  threshold_priority_insert_queue u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .removed_value (removed_value),
    .removed_valid (removed_valid),
    .status        (status),
    .occupancy     (occupancy),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  tpiq_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .removed_value  (removed_value),
    .removed_valid  (removed_valid),
    .status         (status),
    .occupancy      (occupancy),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // one request, with optional idle cycles ahead of it; returns on a falling edge
  task automatic send_request(input logic [KindW-1:0] op, input logic [ValW-1:0] val);
    while (idle_on && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= op;
    value    <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // wait until every result is back, then a settle time of SettleCycles
  task automatic wait_drained();
    while (results_owed != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [ValW-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // values cluster round the threshold and the ends of the range
  function automatic logic [ValW-1:0] pick_value(input logic [ValW-1:0] thr);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return thr;
      3:       return thr - 8'd1;
      4:       return thr + 8'd1;
      default: return ValW'($urandom);
    endcase
  endfunction

  function automatic logic [KindW-1:0] pick_kind(input op_mix_t mix);
    int roll;
    int remove_pct;
    roll       = $urandom_range(0, 99);
    remove_pct = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 62 : 33;
    if (roll < 3)
      return KindUnused;
    if (roll < 3 + remove_pct)
      return K_REMOVE;
    if (roll[0])
      return K_PRIO;
    return K_PLAIN;
  endfunction

  // result side: random back-pressure plus long hold-offs on request
  initial begin : receiver
    int stall_served;
    stall_served = 0;
    out_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_served != stall_req) begin
        stall_served = stall_req;
        out_ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk);
      end else begin
        out_ready <= !idle_on || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // stimulus and verdict
  initial begin : stimulus
    logic [ValW-1:0] phase_thr[PhaseCount];
    int              i;
    int              p;
    rst       = 1'b1;
    in_valid  = 1'b0;
    kind      = K_PLAIN;
    value     = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_on   = 1'b1;
    stall_req = 0;
    cur_thr   = ThrReset;
    repeat (ResetCycles) @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset threshold
    send_request(K_REMOVE, 8'h00);    // remove on empty queue
    send_request(K_PLAIN, 8'd0);
    send_request(K_PRIO, 8'd255);     // head below threshold: goes to head
    send_request(K_PRIO, 8'd59);      // below threshold: tail
    send_request(K_PRIO, 8'd60);      // at threshold: after leading run
    send_request(K_PLAIN, 8'd200);    // priority value but plain: tail
    send_request(K_PRIO, 8'd100);
    send_request(KindUnused, 8'hAA);  // unused code, no change
    send_request(K_REMOVE, 8'h55);
    for (i = 0; i < 11; i++)
      send_request(i[0] ? K_PRIO : K_PLAIN, 8'(i * 23));
    send_request(K_PLAIN, 8'd7);      // insert on full queue
    send_request(K_PRIO, 8'd250);
    repeat (3) send_request(K_REMOVE, 8'hFF);

    // random phases, each at its own threshold
    phase_thr = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd60, 8'd200, 8'd30, 8'd59, 8'd61};
    phase_thr[7] = ValW'($urandom_range(0, 255));
    phase_thr[9] = ValW'($urandom_range(0, 255));
    for (p = 0; p < PhaseCount; p++) begin
      in_valid <= 1'b0;
      wait_drained();
      cur_thr = phase_thr[p];
      write_threshold(cur_thr);
      idle_on = (p != 3);
      for (i = 0; i < PhaseItems; i++) begin
        if ((p == 1 || p == 6) && i == PhaseItems / 3)
          stall_req++;
        send_request(pick_kind(op_mix_t'(p % 3)), pick_value(cur_thr));
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/tpiq_pkg.sv
rtl/tpiq_cell.sv
rtl/threshold_priority_insert_queue.sv
bench/tpiq_result_checker.sv
bench/tb.sv
